// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: sv/elt_pkg.sv
// Types, token codes and character-class functions for the tokenizer.
// Depends on nothing; used by the top level and its checker.
package elt_pkg;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_END  = 1'b1;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   typedef enum logic [5:0] {
      TK_LET    = 6'd0,  TK_LETFUN = 6'd1,  TK_IN     = 6'd2,  TK_IF     = 6'd3,
      TK_ELSE   = 6'd4,  TK_THEN   = 6'd5,  TK_RAND   = 6'd6,  TK_INT    = 6'd7,
      TK_TRUE   = 6'd8,  TK_FALSE  = 6'd9,  TK_IDENT  = 6'd10, TK_ARROW  = 6'd11,
      TK_DARROW = 6'd12, TK_ASSIGN = 6'd13, TK_PLUS   = 6'd14, TK_MINUS  = 6'd15,
      TK_STAR   = 6'd16, TK_SLASH  = 6'd17, TK_COMMA  = 6'd18, TK_EQ     = 6'd19,
      TK_NE     = 6'd20, TK_LE     = 6'd21, TK_GE     = 6'd22, TK_AMP    = 6'd23,
      TK_BSLASH = 6'd24, TK_BAR    = 6'd25, TK_COLON  = 6'd26, TK_LBRACE = 6'd27,
      TK_RBRACE = 6'd28, TK_LPAREN = 6'd29, TK_RPAREN = 6'd30, TK_OR     = 6'd31,
      TK_AND    = 6'd32, TK_PROB   = 6'd33, TK_NOT    = 6'd34, TK_EOF    = 6'd35,
      TK_DUMMY  = 6'd36, TK_ERROR  = 6'd37
   } token_kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_INT,
      MODE_IDENT,
      MODE_MINUS,
      MODE_PAIR
   } scan_mode_type;

   typedef struct packed {
      logic       op;
      logic [7:0] char_byte;
   } req_type;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [15:0] start_position;
      logic [15:0] token_length;
      logic        last_token;
   } rsp_type;

   typedef struct packed {
      logic           hit;
      token_kind_type kind;
   } kind_hit_type;

   localparam logic [55:0] KW_LET    = 56'("let");
   localparam logic [55:0] KW_LETFUN = 56'("letfun");
   localparam logic [55:0] KW_IN     = 56'("in");
   localparam logic [55:0] KW_IF     = 56'("if");
   localparam logic [55:0] KW_ELSE   = 56'("else");
   localparam logic [55:0] KW_THEN   = 56'("then");
   localparam logic [55:0] KW_RAND   = 56'("rand");
   localparam logic [55:0] KW_TRUE   = 56'("true");
   localparam logic [55:0] KW_FALSE  = 56'("false");
   localparam logic [55:0] KW_PROB   = 56'("Prob");
   localparam logic [55:0] KW_NOT    = 56'("not");
   localparam logic [55:0] KW_DUMMY  = 56'("dummy");

   function automatic logic is_space(input logic [7:0] c);
      return (c inside {8'd32, [8'd9:8'd13]});
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c inside {["0":"9"]});
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c inside {["a":"z"], ["A":"Z"]});
   endfunction

   function automatic logic is_pair_start(input logic [7:0] c);
      return (c inside {"=", "!", "<", ">", "\\", "/"});
   endfunction

   function automatic kind_hit_type single_kind(input logic [7:0] c);
      kind_hit_type r;
      r.hit  = 1'b1;
      r.kind = TK_ERROR;
      case (c)
         "=":     r.kind = TK_ASSIGN;
         "+":     r.kind = TK_PLUS;
         "-":     r.kind = TK_MINUS;
         "*":     r.kind = TK_STAR;
         "/":     r.kind = TK_SLASH;
         ",":     r.kind = TK_COMMA;
         "&":     r.kind = TK_AMP;
         "\\":    r.kind = TK_BSLASH;
         "|":     r.kind = TK_BAR;
         ":":     r.kind = TK_COLON;
         "{":     r.kind = TK_LBRACE;
         "}":     r.kind = TK_RBRACE;
         "(":     r.kind = TK_LPAREN;
         ")":     r.kind = TK_RPAREN;
         default: r.hit  = 1'b0;
      endcase
      return r;
   endfunction

   function automatic kind_hit_type pair_kind(input logic [7:0] a, input logic [7:0] b);
      kind_hit_type r;
      r.hit  = 1'b1;
      r.kind = TK_ERROR;
      if (a == "=" && b == ">")       r.kind = TK_DARROW;
      else if (a == "=" && b == "=")  r.kind = TK_EQ;
      else if (a == "!" && b == "=")  r.kind = TK_NE;
      else if (a == "<" && b == "=")  r.kind = TK_LE;
      else if (a == ">" && b == "=")  r.kind = TK_GE;
      else if (a == "\\" && b == "/") r.kind = TK_OR;
      else if (a == "/" && b == "\\") r.kind = TK_AND;
      else                            r.hit  = 1'b0;
      return r;
   endfunction

   function automatic token_kind_type keyword_kind(input logic [55:0] w);
      token_kind_type k;
      case (w)
         KW_LET:    k = TK_LET;
         KW_LETFUN: k = TK_LETFUN;
         KW_IN:     k = TK_IN;
         KW_IF:     k = TK_IF;
         KW_ELSE:   k = TK_ELSE;
         KW_THEN:   k = TK_THEN;
         KW_RAND:   k = TK_RAND;
         KW_TRUE:   k = TK_TRUE;
         KW_FALSE:  k = TK_FALSE;
         KW_PROB:   k = TK_PROB;
         KW_NOT:    k = TK_NOT;
         KW_DUMMY:  k = TK_DUMMY;
         default:   k = TK_IDENT;
      endcase
      return k;
   endfunction

endpackage

// File: sv/expression_language_tokenizer.sv
// Tokenizer top level: scan state, token building and a four-entry result queue.
// Depends on elt_pkg.
// A token is written into the result queue by the transfer that completes it.
// Throughput: one character per cycle; req_ready is high while the result queue
// holds two entries or fewer, so an item that completes two tokens finds room
// for both. Reset (synchronous) empties the queue and returns to position zero.
module expression_language_tokenizer #(
   parameter int POSITION_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  elt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output elt_pkg::rsp_type rsp_data
);

   localparam int PB = POSITION_BITS;

   elt_pkg::scan_mode_type mode_ff, mode_in;
   logic [7:0]    pend_char_ff, pend_char_in;
   logic [PB-1:0] pos_ff, pos_in, pos_inc;
   logic [PB-1:0] start_ff, start_in;
   logic [55:0]   window_ff, window_in;
   logic          discard_ff, discard_in;
   logic [15:0]   len_ff, len_in, len_inc;

   elt_pkg::rsp_type                     queue_ff [elt_pkg::QUEUE_DEPTH];
   logic [elt_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [elt_pkg::QUEUE_CNT_BITS-1:0]   count_ff, count_in;

   logic             accept, pop, handled;
   logic [1:0]       n;
   elt_pkg::rsp_type r0, r1;
   logic [7:0]       c;

   logic             close_emit, close_err;
   elt_pkg::rsp_type close_rsp;
   elt_pkg::kind_hit_type close_sk, beg_sk, pk;

   logic             beg_emit, beg_err;
   elt_pkg::scan_mode_type beg_mode;
   elt_pkg::rsp_type beg_rsp;

   function automatic logic [15:0] clip16(input logic [PB-1:0] v);
      logic [32:0] w;
      w = 33'(v);
      return (w > 33'h0FFFF) ? 16'hFFFF : w[15:0];
   endfunction

   assign c         = req_data.char_byte;
   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (count_ff <= elt_pkg::QUEUE_CNT_BITS'(elt_pkg::QUEUE_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign pos_inc   = (pos_ff == '1) ? pos_ff : pos_ff + PB'(1);
   assign len_inc   = (len_ff == 16'hFFFF) ? len_ff : len_ff + 16'd1;
   assign pk        = elt_pkg::pair_kind(pend_char_ff, c);

   // Token that the current state holds, reported as complete.
   always_comb begin
      close_emit = 1'b0;
      close_err  = 1'b0;
      close_sk   = elt_pkg::single_kind(pend_char_ff);
      close_rsp.token_kind     = elt_pkg::TK_INT;
      close_rsp.start_position = clip16(start_ff);
      close_rsp.token_length   = 16'd1;
      close_rsp.last_token     = 1'b0;
      case (mode_ff)
         elt_pkg::MODE_INT: begin
            close_emit             = 1'b1;
            close_rsp.token_length = len_ff;
         end
         elt_pkg::MODE_IDENT: begin
            close_emit             = 1'b1;
            close_rsp.token_length = len_ff;
            close_rsp.token_kind   = (len_ff <= 16'd6) ? elt_pkg::keyword_kind(window_ff)
                                                       : elt_pkg::TK_IDENT;
         end
         elt_pkg::MODE_MINUS: begin
            close_emit           = 1'b1;
            close_rsp.token_kind = elt_pkg::TK_MINUS;
         end
         elt_pkg::MODE_PAIR: begin
            close_emit = 1'b1;
            if (close_sk.hit) begin
               close_rsp.token_kind = close_sk.kind;
            end else begin
               close_err            = 1'b1;
               close_rsp.token_kind = elt_pkg::TK_ERROR;
               close_rsp.last_token = 1'b1;
            end
         end
         default: begin
            close_emit = 1'b0;
         end
      endcase
   end

   // Token started by the incoming character with nothing pending.
   always_comb begin
      beg_emit = 1'b0;
      beg_err  = 1'b0;
      beg_mode = elt_pkg::MODE_IDLE;
      beg_sk   = elt_pkg::single_kind(c);
      beg_rsp.token_kind     = beg_sk.kind;
      beg_rsp.start_position = clip16(pos_ff);
      beg_rsp.token_length   = 16'd1;
      beg_rsp.last_token     = 1'b0;
      if (elt_pkg::is_space(c)) begin
         beg_mode = elt_pkg::MODE_IDLE;
      end else if (elt_pkg::is_digit(c)) begin
         beg_mode = elt_pkg::MODE_INT;
      end else if (c == "-") begin
         beg_mode = elt_pkg::MODE_MINUS;
      end else if (elt_pkg::is_pair_start(c)) begin
         beg_mode = elt_pkg::MODE_PAIR;
      end else if (elt_pkg::is_alpha(c)) begin
         beg_mode = elt_pkg::MODE_IDENT;
      end else begin
         beg_emit = 1'b1;
         if (!beg_sk.hit) begin
            beg_err            = 1'b1;
            beg_rsp.token_kind = elt_pkg::TK_ERROR;
            beg_rsp.last_token = 1'b1;
         end
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      pend_char_in = pend_char_ff;
      pos_in       = pos_ff;
      start_in     = start_ff;
      window_in    = window_ff;
      discard_in   = discard_ff;
      len_in       = len_ff;
      handled      = 1'b0;
      n            = 2'd0;
      r0           = close_rsp;
      r1           = close_rsp;
      if (accept) begin
         if (req_data.op == elt_pkg::OP_END) begin
            if (!discard_ff) begin
               if (close_emit) begin
                  r0 = close_rsp;
                  n  = 2'd1;
               end
               if (!close_err) begin
                  r1.token_kind     = elt_pkg::TK_EOF;
                  r1.start_position = clip16(pos_ff);
                  r1.token_length   = 16'd0;
                  r1.last_token     = 1'b1;
                  if (n == 2'd0) begin
                     r0 = r1;
                  end
                  n = n + 2'd1;
               end
            end
            // Start a fresh stream.
            mode_in      = elt_pkg::MODE_IDLE;
            pend_char_in = '0;
            pos_in       = '0;
            start_in     = '0;
            window_in    = '0;
            discard_in   = 1'b0;
            len_in       = '0;
         end else if (!discard_ff) begin
            pos_in = pos_inc;
            case (mode_ff)
               elt_pkg::MODE_INT: begin
                  if (elt_pkg::is_digit(c)) begin
                     len_in  = len_inc;
                     handled = 1'b1;
                  end
               end
               elt_pkg::MODE_IDENT: begin
                  if (elt_pkg::is_alpha(c) || elt_pkg::is_digit(c) || c == "_") begin
                     len_in  = len_inc;
                     handled = 1'b1;
                     if (len_inc <= 16'd7) begin
                        window_in = {window_ff[47:0], c};
                     end
                  end
               end
               elt_pkg::MODE_MINUS: begin
                  if (elt_pkg::is_digit(c)) begin
                     mode_in = elt_pkg::MODE_INT;
                     len_in  = 16'd2;
                     handled = 1'b1;
                  end else if (c == ">") begin
                     r0.token_kind   = elt_pkg::TK_ARROW;
                     r0.token_length = 16'd2;
                     r0.last_token   = 1'b0;
                     n       = 2'd1;
                     mode_in = elt_pkg::MODE_IDLE;
                     handled = 1'b1;
                  end
               end
               elt_pkg::MODE_PAIR: begin
                  if (pk.hit) begin
                     r0.token_kind   = pk.kind;
                     r0.token_length = 16'd2;
                     r0.last_token   = 1'b0;
                     n       = 2'd1;
                     mode_in = elt_pkg::MODE_IDLE;
                     handled = 1'b1;
                  end
               end
               default: begin
                  handled = 1'b0;
               end
            endcase
            if (!handled) begin
               mode_in = elt_pkg::MODE_IDLE;
               if (close_emit) begin
                  r0 = close_rsp;
                  n  = 2'd1;
               end
               if (close_err) begin
                  discard_in = 1'b1;
               end else begin
                  mode_in = beg_mode;
                  if (!elt_pkg::is_space(c)) begin
                     start_in = pos_ff;
                     len_in   = 16'd1;
                  end
                  if (beg_mode == elt_pkg::MODE_PAIR) begin
                     pend_char_in = c;
                  end
                  if (beg_mode == elt_pkg::MODE_IDENT) begin
                     window_in = {48'd0, c};
                  end
                  if (beg_emit) begin
                     if (n == 2'd0) begin
                        r0 = beg_rsp;
                     end else begin
                        r1 = beg_rsp;
                     end
                     n = n + 2'd1;
                  end
                  if (beg_err) begin
                     discard_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + elt_pkg::QUEUE_PTR_BITS'(n);
      rd_ptr_in = pop ? rd_ptr_ff + elt_pkg::QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + elt_pkg::QUEUE_CNT_BITS'(n)
                  - elt_pkg::QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= elt_pkg::MODE_IDLE;
         pend_char_ff <= '0;
         pos_ff       <= '0;
         start_ff     <= '0;
         window_ff    <= '0;
         discard_ff   <= 1'b0;
         len_ff       <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         mode_ff      <= mode_in;
         pend_char_ff <= pend_char_in;
         pos_ff       <= pos_in;
         start_ff     <= start_in;
         window_ff    <= window_in;
         discard_ff   <= discard_in;
         len_ff       <= len_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
      end
   end

   // Queue payload; a second token lands in the slot after the first.
   always_ff @(posedge clock) begin
      if (n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= r0;
      end
      if (n == 2'd2) begin
         queue_ff[wr_ptr_ff + elt_pkg::QUEUE_PTR_BITS'(1)] <= r1;
      end
   end

endmodule

// File: sv/elt_checker.sv
// Port-level checks for the tokenizer, bound to the top level.
// Depends on elt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module elt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input elt_pkg::rsp_type rsp_data
);

   logic is_error, is_eof, error_shape, eof_shape;

   assign is_error    = rsp_valid && rsp_data.token_kind == elt_pkg::TK_ERROR;
   assign is_eof      = rsp_valid && rsp_data.token_kind == elt_pkg::TK_EOF;
   assign error_shape = rsp_data.last_token && rsp_data.token_length == 16'd1;
   assign eof_shape   = rsp_data.last_token && rsp_data.token_length == 16'd0;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready)
   `ASSERT_SAME(a_error_shape, clock, reset, is_error, error_shape)
   `ASSERT_SAME(a_eof_shape, clock, reset, is_eof, eof_shape)

endmodule

bind expression_language_tokenizer elt_checker u_elt_checker (.*);

// File: bench/tb_expression_language_tokenizer.sv
// Self-checking bench for expression_language_tokenizer: drives character streams,
// predicts the token stream in a scoreboard class and checks every result transfer.
// Depends on elt_pkg and the tokenizer RTL.
`timescale 1ns / 1ps

module tb_expression_language_tokenizer;

   class token_scoreboard;
      elt_pkg::rsp_type       expected_tokens[$];
      int                     failures;
      elt_pkg::scan_mode_type mode;
      logic [7:0]             pair_ch;
      logic [15:0]            char_pos;
      logic [15:0]            tok_start;
      int unsigned            tok_len;
      logic [55:0]            kw_win;
      bit                     discarding;

      function new();
         failures = 0;
         clear();
      endfunction

      function void clear();
         mode       = elt_pkg::MODE_IDLE;
         pair_ch    = 8'd0;
         char_pos   = 16'd0;
         tok_start  = 16'd0;
         tok_len    = 0;
         kw_win     = 56'd0;
         discarding = 1'b0;
      endfunction

      function bit blank(logic [7:0] c);
         return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
      endfunction

      function bit numeral(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function bit letter(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function bit single_token(logic [7:0] c, output elt_pkg::token_kind_type k);
         k = elt_pkg::TK_ERROR;
         case (c)
            "=":     k = elt_pkg::TK_ASSIGN;
            "+":     k = elt_pkg::TK_PLUS;
            "-":     k = elt_pkg::TK_MINUS;
            "*":     k = elt_pkg::TK_STAR;
            "/":     k = elt_pkg::TK_SLASH;
            ",":     k = elt_pkg::TK_COMMA;
            "&":     k = elt_pkg::TK_AMP;
            "\\":    k = elt_pkg::TK_BSLASH;
            "|":     k = elt_pkg::TK_BAR;
            ":":     k = elt_pkg::TK_COLON;
            "{":     k = elt_pkg::TK_LBRACE;
            "}":     k = elt_pkg::TK_RBRACE;
            "(":     k = elt_pkg::TK_LPAREN;
            ")":     k = elt_pkg::TK_RPAREN;
            default: return 1'b0;
         endcase
         return 1'b1;
      endfunction

      function bit paired_token(logic [7:0] a, logic [7:0] b,
                                output elt_pkg::token_kind_type k);
         k = elt_pkg::TK_ERROR;
         case ({a, b})
            "=>":    k = elt_pkg::TK_DARROW;
            "==":    k = elt_pkg::TK_EQ;
            "!=":    k = elt_pkg::TK_NE;
            "<=":    k = elt_pkg::TK_LE;
            ">=":    k = elt_pkg::TK_GE;
            "\\/":   k = elt_pkg::TK_OR;
            "/\\":   k = elt_pkg::TK_AND;
            default: return 1'b0;
         endcase
         return 1'b1;
      endfunction

      function elt_pkg::token_kind_type word_token();
         if (tok_len > 6) return elt_pkg::TK_IDENT;
         case (kw_win)
            "let":    return elt_pkg::TK_LET;
            "letfun": return elt_pkg::TK_LETFUN;
            "in":     return elt_pkg::TK_IN;
            "if":     return elt_pkg::TK_IF;
            "else":   return elt_pkg::TK_ELSE;
            "then":   return elt_pkg::TK_THEN;
            "rand":   return elt_pkg::TK_RAND;
            "true":   return elt_pkg::TK_TRUE;
            "false":  return elt_pkg::TK_FALSE;
            "Prob":   return elt_pkg::TK_PROB;
            "not":    return elt_pkg::TK_NOT;
            "dummy":  return elt_pkg::TK_DUMMY;
            default:  return elt_pkg::TK_IDENT;
         endcase
      endfunction

      function void push_token(elt_pkg::token_kind_type k, logic [15:0] at,
                               int unsigned len, logic last);
         elt_pkg::rsp_type t;
         t.token_kind     = k;
         t.start_position = at;
         t.token_length   = (len > 65535) ? 16'hFFFF : len[15:0];
         t.last_token     = last;
         expected_tokens  = {expected_tokens, t};
      endfunction

      function void flag_error(logic [15:0] at);
         push_token(elt_pkg::TK_ERROR, at, 1, 1'b1);
         discarding = 1'b1;
         mode       = elt_pkg::MODE_IDLE;
      endfunction

      // Report the pending token; returns 0 when a lone bang or angle became an error.
      function bit close_token();
         elt_pkg::token_kind_type k;
         case (mode)
            elt_pkg::MODE_INT:   push_token(elt_pkg::TK_INT, tok_start, tok_len, 1'b0);
            elt_pkg::MODE_IDENT: push_token(word_token(), tok_start, tok_len, 1'b0);
            elt_pkg::MODE_MINUS: push_token(elt_pkg::TK_MINUS, tok_start, 1, 1'b0);
            elt_pkg::MODE_PAIR: begin
               if (!single_token(pair_ch, k)) begin
                  flag_error(tok_start);
                  return 1'b0;
               end
               push_token(k, tok_start, 1, 1'b0);
            end
            default: ;
         endcase
         mode = elt_pkg::MODE_IDLE;
         return 1'b1;
      endfunction

      function void open_token(logic [7:0] c, logic [15:0] at);
         elt_pkg::token_kind_type k;
         mode = elt_pkg::MODE_IDLE;
         if (blank(c)) return;
         tok_start = at;
         tok_len   = 1;
         if (numeral(c)) begin
            mode = elt_pkg::MODE_INT;
         end else if (c == "-") begin
            mode = elt_pkg::MODE_MINUS;
         end else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "\\" || c == "/") begin
            mode    = elt_pkg::MODE_PAIR;
            pair_ch = c;
         end else if (letter(c)) begin
            mode   = elt_pkg::MODE_IDENT;
            kw_win = {48'd0, c};
         end else if (single_token(c, k)) begin
            push_token(k, at, 1, 1'b0);
         end else begin
            flag_error(at);
         end
      endfunction

      function void note_request(elt_pkg::req_type r);
         logic [7:0]              c;
         logic [15:0]             at;
         elt_pkg::token_kind_type k;
         c = r.char_byte;
         if (r.op == elt_pkg::OP_END) begin
            if (!discarding && close_token()) push_token(elt_pkg::TK_EOF, char_pos, 0, 1'b1);
            clear();
            return;
         end
         if (discarding) return;
         at = char_pos;
         if (char_pos != 16'hFFFF) char_pos++;
         case (mode)
            elt_pkg::MODE_INT: begin
               if (numeral(c)) begin
                  if (tok_len < 65535) tok_len++;
                  return;
               end
            end
            elt_pkg::MODE_IDENT: begin
               if (letter(c) || numeral(c) || c == "_") begin
                  if (tok_len < 65535) tok_len++;
                  if (tok_len <= 7) kw_win = {kw_win[47:0], c};
                  return;
               end
            end
            elt_pkg::MODE_MINUS: begin
               if (numeral(c)) begin
                  mode    = elt_pkg::MODE_INT;
                  tok_len = 2;
                  return;
               end
               if (c == ">") begin
                  push_token(elt_pkg::TK_ARROW, tok_start, 2, 1'b0);
                  mode = elt_pkg::MODE_IDLE;
                  return;
               end
            end
            elt_pkg::MODE_PAIR: begin
               if (paired_token(pair_ch, c, k)) begin
                  push_token(k, tok_start, 2, 1'b0);
                  mode = elt_pkg::MODE_IDLE;
                  return;
               end
            end
            default: ;
         endcase
         if (!close_token()) return;
         open_token(c, at);
      endfunction

      function void mismatch(string field, int unsigned want, int unsigned got);
         failures++;
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      endfunction

      function void check_token(elt_pkg::rsp_type got);
         elt_pkg::rsp_type want;
         if (expected_tokens.size() == 0) begin
            failures++;
            $display("%0t: token expected none, got kind %0d start %0d length %0d last %0b",
                     $time, got.token_kind, got.start_position, got.token_length,
                     got.last_token);
            return;
         end
         want = expected_tokens.pop_front();
         if (got.token_kind != want.token_kind)
            mismatch("token_kind", want.token_kind, got.token_kind);
         if (got.start_position != want.start_position)
            mismatch("start_position", want.start_position, got.start_position);
         if (got.token_length != want.token_length)
            mismatch("token_length", want.token_length, got.token_length);
         if (got.last_token != want.last_token)
            mismatch("last_token", want.last_token, got.last_token);
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   elt_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   elt_pkg::rsp_type rsp_data;

   token_scoreboard board;
   int item_count    = 0;
   int send_gap_pct  = 0;
   bit hold_out      = 1'b0;
   bit quiet         = 1'b0;

   string keyword_list[12] = '{"let", "letfun", "in", "if", "else", "then", "rand",
                               "true", "false", "Prob", "not", "dummy"};
   string operator_list[22] = '{"->", "=>", "==", "!=", "<=", ">=", "\\/", "/\\", "=",
                                "+", "-", "*", "/", ",", "&", "\\", "|", ":", "{", "}",
                                "(", ")"};

   expression_language_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_token(rsp_data);
   end

   // Result side: random stall bursts, a long hold-off on request, none when quiet.
   initial begin
      int stall_pct;
      int window_left;
      rsp_ready   = 1'b0;
      stall_pct   = 0;
      window_left = 0;
      forever begin
         @(negedge clock);
         if (window_left == 0) begin
            window_left = $urandom_range(20, 200);
            case ($urandom_range(0, 3))
               0, 1:    stall_pct = 0;
               2:       stall_pct = 10;
               default: stall_pct = 35;
            endcase
         end
         window_left--;
         if (hold_out) begin
            rsp_ready = 1'b0;
            repeat (299) @(negedge clock);
            hold_out = 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(0, 18)) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   task automatic send_req(input logic op, input logic [7:0] c);
      elt_pkg::req_type r;
      r.op        = op;
      r.char_byte = c;
      if (!quiet && send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 18)) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == elt_pkg::OP_END || !board.discarding) item_count++;
      board.note_request(r);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_req(elt_pkg::OP_CHAR, s[i]);
   endtask

   task automatic end_stream();
      send_req(elt_pkg::OP_END, 8'($urandom));
   endtask

   task automatic send_blank();
      case ($urandom_range(0, 7))
         0:       send_req(elt_pkg::OP_CHAR, 8'd9);
         1:       send_req(elt_pkg::OP_CHAR, 8'd10);
         2:       send_req(elt_pkg::OP_CHAR, 8'd11);
         3:       send_req(elt_pkg::OP_CHAR, 8'd12);
         4:       send_req(elt_pkg::OP_CHAR, 8'd13);
         default: send_req(elt_pkg::OP_CHAR, 8'd32);
      endcase
   endtask

   function automatic logic [7:0] word_char();
      int r;
      r = $urandom_range(0, 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r < 62) return 8'("0" + r - 52);
      return "_";
   endfunction

   function automatic string random_lexeme();
      string s;
      int    sel;
      int    n;
      sel = $urandom_range(0, 99);
      s   = "";
      if (sel < 20) begin
         s = keyword_list[$urandom_range(0, 11)];
      end else if (sel < 38) begin
         // mostly fresh words, some keyword prefixes or extensions
         if ($urandom_range(0, 2) == 0) begin
            s = keyword_list[$urandom_range(0, 11)];
            if ($urandom_range(0, 1) == 0) s = s.substr(0, s.len() - 2);
         end else begin
            s = $sformatf("%c", $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                                      : 8'("A" + $urandom_range(0, 25)));
         end
         n = $urandom_range(0, 8);
         repeat (n) s = $sformatf("%s%c", s, word_char());
         if (s.len() == 0) s = "z";
      end else if (sel < 55) begin
         if ($urandom_range(0, 2) == 0) s = "-";
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
         repeat (n) s = $sformatf("%s%c", s, 8'("0" + $urandom_range(0, 9)));
      end else begin
         s = operator_list[$urandom_range(0, 21)];
      end
      return s;
   endfunction

   task automatic send_noise();
      case ($urandom_range(0, 5))
         0:       send_req(elt_pkg::OP_CHAR, "!");
         1:       send_req(elt_pkg::OP_CHAR, "<");
         2:       send_req(elt_pkg::OP_CHAR, ">");
         3:       send_req(elt_pkg::OP_CHAR, "_");
         default: send_req(elt_pkg::OP_CHAR, 8'($urandom));
      endcase
   endtask

   task automatic play_stream(input int lexemes, input bit broken);
      int bad_at;
      bad_at = broken ? $urandom_range(0, lexemes) : -1;
      for (int i = 0; i <= lexemes; i++) begin
         if (i == bad_at) send_noise();
         if (i < lexemes) begin
            send_text(random_lexeme());
            if ($urandom_range(0, 99) < 55) begin
               repeat ($urandom_range(1, 3)) send_blank();
            end
         end
      end
      end_stream();
   endtask

   // Drop valid after the last transfer, then wait for every expected token.
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.expected_tokens.size() != 0) @(posedge clock);
   endtask

   initial begin
      #20_000_000;
      $display("tb_expression_language_tokenizer failed");
      $finish;
   end

   initial begin
      board     = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: pairs against singles, signed integer, lone bang and angle,
      // empty stream, unknown bytes at both ends of the range, discard after error
      send_text("if a1<=-12/\\b");
      end_stream();
      send_text("!");
      end_stream();
      end_stream();
      send_req(elt_pkg::OP_CHAR, "q");
      send_req(elt_pkg::OP_CHAR, 8'h00);
      send_req(elt_pkg::OP_CHAR, "z");
      end_stream();
      send_req(elt_pkg::OP_CHAR, 8'hFF);
      end_stream();
      send_text("<a");
      end_stream();

      // hold the result side while transfers keep coming, then drain completely
      wait_drained();
      hold_out     = 1'b1;
      send_gap_pct = 0;
      play_stream(30, 1'b0);
      wait_drained();

      while (item_count < 1450) begin
         case ($urandom_range(0, 4))
            0, 1:    send_gap_pct = 0;
            2:       send_gap_pct = 5;
            3:       send_gap_pct = 20;
            default: send_gap_pct = 50;
         endcase
         play_stream($urandom_range(0, 14), $urandom_range(0, 4) == 0);
      end

      quiet = 1'b1;
      while (item_count < 1550) play_stream($urandom_range(0, 14), $urandom_range(0, 4) == 0);

      @(negedge clock);
      req_valid = 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (board.failures == 0) begin
         $display("tb_expression_language_tokenizer passed");
      end else begin
         $display("tb_expression_language_tokenizer failed");
      end
      $finish;
   end

endmodule

// File: expression_language_tokenizer.f
+incdir+sv
sv/elt_pkg.sv
sv/expression_language_tokenizer.sv
sv/elt_checker.sv
bench/tb_expression_language_tokenizer.sv
